@@ hdl/rgsd_pkg.sv @@
// ----------------------------------------------------------------------------
// rgsd_pkg: shared types and constants for the rank gather-sum-divide block
// Transaction structs, request codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package rgsd_pkg;

  // fixed field widths of the transactions
  localparam int IDX_BITS       = 14;
  localparam int VAL_FIELD_BITS = 64;
  localparam int CNT_BITS       = 16;

  // default sizes of the block
  localparam int RANK_ENTRIES_DEF = 16384;
  localparam int VALUE_BITS_DEF   = 64;

  // request codes; the fourth code is unused and ignored
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_HEADER = 2'd1,
    REQ_EDGE   = 2'd2
  } rgsd_req_e;

  // input transaction
  typedef struct packed {
    logic [1:0]                req_type;
    logic [IDX_BITS-1:0]       entry_index;
    logic [VAL_FIELD_BITS-1:0] rank_value;
    logic [CNT_BITS-1:0]       in_count;
    logic [CNT_BITS-1:0]       out_count;
  } rgsd_in_t;

  // output transaction
  typedef struct packed {
    logic [VAL_FIELD_BITS-1:0] weight;
    logic [IDX_BITS-1:0]       vertex_number;
  } rgsd_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_START,
    ST_DIV,
    ST_OUT
  } rgsd_state_e;

  // rank store port controls
  typedef struct packed {
    logic we;
    logic re;
  } rgsd_mem_ctl_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } rgsd_div_stat_t;

endpackage

@@ hdl/rank_gather_sum_divide.sv @@
// ----------------------------------------------------------------------------
// rank_gather_sum_divide: one pull-style rank iteration without damping
// Rank store, edge accumulator, sequencer and iterative divider.
// ----------------------------------------------------------------------------
// Load transactions to an in-range entry write the rank store while no vertex
// is open. A vertex header opens a vertex; each in-edge is a registered read
// of the single-port rank store, then the add. When a vertex finishes, after
// its last edge or at once for an empty header, the block sets up the divide
// (ST_START), waits on the bit-serial divider (ST_DIV, skipped for a zero
// out-count) and hands the result to the output register (ST_OUT), waiting
// there while the output register stays stalled. Input is stalled while a
// transaction is being worked on. A finished result waits in the output
// register while new input is taken.
module rank_gather_sum_divide #(
  parameter int RANK_ENTRIES = rgsd_pkg::RANK_ENTRIES_DEF,
  parameter int VALUE_BITS   = rgsd_pkg::VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rgsd_pkg::rgsd_in_t in_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output rgsd_pkg::rgsd_out_t out_o,
  output logic               out_valid_o,
  input  logic               out_stall_i
);
  import rgsd_pkg::*;

  localparam int ADDR_W = $clog2(RANK_ENTRIES);

  rgsd_state_e           state_q, state_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [CNT_BITS-1:0]   edges_left_q, edges_left_d;
  logic [CNT_BITS-1:0]   held_oc_q, held_oc_d;
  logic                  pending_q, pending_d;
  logic [IDX_BITS-1:0]   vcnt_q, vcnt_d;
  logic                  edge_hit_q, edge_hit_d;
  logic                  out_valid_q, out_valid_d;
  rgsd_out_t             out_q, out_d;
  logic                  out_load;

  rgsd_mem_ctl_t         mem_ctl;
  logic [VALUE_BITS-1:0] rd_data;
  logic                  in_range;
  logic                  out_free;

  logic                  div_start;
  logic [VALUE_BITS-1:0] quotient;
  rgsd_div_stat_t        div_stat;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_range   = 32'(in_i.entry_index) < 32'(RANK_ENTRIES);
  assign out_free   = !out_valid_q || !out_stall_i;

  // rank store
  rgsd_store #(
    .DEPTH (RANK_ENTRIES),
    .WIDTH (VALUE_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .addr_i    (ADDR_W'(in_i.entry_index)),
    .wr_data_i (in_i.rank_value[VALUE_BITS-1:0]),
    .rd_data_o (rd_data)
  );

  // shared divider
  rgsd_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (held_oc_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // sequencer next state and outputs
  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    edges_left_d = edges_left_q;
    held_oc_d    = held_oc_q;
    pending_d    = pending_q;
    vcnt_d       = vcnt_q;
    edge_hit_d   = edge_hit_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    out_load     = 1'b0;
    mem_ctl      = '0;
    div_start    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_i.req_type)
            REQ_LOAD: begin
              mem_ctl.we = !pending_q && in_range;
            end
            REQ_HEADER: begin
              if (!pending_q) begin
                acc_d        = '0;
                held_oc_d    = in_i.out_count;
                edges_left_d = in_i.in_count;
                pending_d    = 1'b1;
                if (in_i.in_count == '0) begin
                  state_d = ST_START;
                end
              end
            end
            REQ_EDGE: begin
              if (pending_q) begin
                mem_ctl.re = 1'b1;
                edge_hit_d = in_range;
                state_d    = ST_ADD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD: begin
        if (edge_hit_q) begin
          acc_d = acc_q + rd_data;
        end
        edges_left_d = edges_left_q - CNT_BITS'(1);
        state_d      = (edges_left_q == CNT_BITS'(1)) ? ST_START : ST_IDLE;
      end
      ST_START: begin
        if (held_oc_q == '0) begin
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_valid_d         = 1'b1;
          out_d.weight        = (held_oc_q == '0) ? '0 : VAL_FIELD_BITS'(quotient);
          out_d.vertex_number = vcnt_q;
          vcnt_d              = vcnt_q + IDX_BITS'(1);
          pending_d           = 1'b0;
          edges_left_d        = '0;
          acc_d               = '0;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      acc_q        <= '0;
      edges_left_q <= '0;
      held_oc_q    <= '0;
      pending_q    <= 1'b0;
      vcnt_q       <= '0;
      edge_hit_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      acc_q        <= acc_d;
      edges_left_q <= edges_left_d;
      held_oc_q    <= held_oc_d;
      pending_q    <= pending_d;
      vcnt_q       <= vcnt_d;
      edge_hit_q   <= edge_hit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // divider is never restarted while working
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // a divide only runs for a nonzero out-count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> held_oc_q != '0)
    else $error("divide finished with zero divisor");

  // the add cycle always follows an accepted edge transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADD |-> $past(in_valid_i && !in_stall_o && in_i.req_type == REQ_EDGE))
    else $error("add cycle without an edge transaction");

  // no edges remain counted when no vertex is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !pending_q) |-> edges_left_q == '0)
    else $error("edge count left without an open vertex");
`endif

endmodule

@@ hdl/rgsd_store.sv @@
// ----------------------------------------------------------------------------
// rgsd_store: rank store memory
// Single-port memory, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module rgsd_store #(
  parameter int DEPTH = rgsd_pkg::RANK_ENTRIES_DEF,
  parameter int WIDTH = rgsd_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  rgsd_pkg::rgsd_mem_ctl_t    ctl_i,
  input  logic [$clog2(DEPTH)-1:0]   addr_i,
  input  logic [WIDTH-1:0]           wr_data_i,
  output logic [WIDTH-1:0]           rd_data_o
);
  import rgsd_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rd_data_q <= mem[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/rgsd_divider.sv @@
// ----------------------------------------------------------------------------
// rgsd_divider: iterative restoring divider
// One quotient bit per cycle; the dividend register collects the quotient.
// ----------------------------------------------------------------------------
module rgsd_divider #(
  parameter int VALUE_BITS = rgsd_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [VALUE_BITS-1:0]         dividend_i,
  input  logic [rgsd_pkg::CNT_BITS-1:0] divisor_i,
  output logic [VALUE_BITS-1:0]         quotient_o,
  output rgsd_pkg::rgsd_div_stat_t      stat_o
);
  import rgsd_pkg::*;

  localparam int STEP_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] dvd_q, dvd_d;
  logic [CNT_BITS-1:0]   rem_q, rem_d;
  logic [CNT_BITS-1:0]   dsr_q, dsr_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [CNT_BITS:0]     rem_shift;
  logic [CNT_BITS:0]     rem_sub;
  logic                  fits;

  // one restoring step
  assign rem_shift = {rem_q, dvd_q[VALUE_BITS-1]};
  assign fits      = rem_shift >= {1'b0, dsr_q};
  assign rem_sub   = rem_shift - {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      step_d = STEP_W'(VALUE_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[VALUE_BITS-2:0], fits};
      rem_d  = fits ? rem_sub[CNT_BITS-1:0] : rem_shift[CNT_BITS-1:0];
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o  = dvd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rank_gather_sum_divide
// Runs a table of directed transactions, then random load/header/edge
// sequences mixed with protocol noise. Every accepted input transaction goes
// through a local rank-gather predictor. Every accepted weight is checked
// field by field against the oldest predicted weight.
// ----------------------------------------------------------------------------
module testbench;
  import rgsd_pkg::*;

  localparam int          RANK_DEPTH  = RANK_ENTRIES_DEF;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          RAND_ITEMS  = 1400;
  localparam int          SETTLE      = 200;

  // one directed row: transaction plus an optional hand-written weight
  typedef struct {
    rgsd_in_t  item;
    bit        typed;
    rgsd_out_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  rgsd_in_t  in_item  = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  rgsd_out_t out_res;
  logic      out_valid;
  logic      out_stall = 1'b0;

  // rank-gather predictor state
  logic [63:0]  rank_mem [RANK_DEPTH];
  bit           rank_loaded [RANK_DEPTH];
  int unsigned  loaded_list [$];
  logic [63:0]  acc_sum    = '0;
  logic [15:0]  edges_left = '0;
  logic [15:0]  held_div   = '0;
  bit           vtx_open   = 1'b0;
  logic [13:0]  vtx_seq    = '0;

  // predicted weights waiting for the output side
  rgsd_out_t weight_q [$];

  // bench bookkeeping
  bit          calm      = 1'b0;
  bit          row_typed = 1'b0;
  rgsd_out_t   row_want  = '0;
  int unsigned n_taken   = 0;
  int unsigned n_weights = 0;
  int unsigned n_pauses  = 0;
  int unsigned n_errors  = 0;
  int unsigned quiet     = 0;
  dir_row_t    dir_rows [$];

  rank_gather_sum_divide dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_item),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .out_o      (out_res),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // close the open vertex and form its weight
  function automatic void close_vertex(output rgsd_out_t r);
    r.weight        = (held_div == 16'd0) ? 64'd0 : acc_sum / {48'd0, held_div};
    r.vertex_number = vtx_seq;
    vtx_seq    = vtx_seq + 14'd1;
    vtx_open   = 1'b0;
    edges_left = '0;
    acc_sum    = '0;
  endfunction

  // advance the predictor by one transaction; returns 1 when a weight results
  function automatic bit gather_step(input rgsd_in_t t, output rgsd_out_t r);
    r = '0;
    case (t.req_type)
      REQ_LOAD: begin
        if (!vtx_open) begin
          rank_mem[t.entry_index] = t.rank_value;
          if (!rank_loaded[t.entry_index]) begin
            rank_loaded[t.entry_index] = 1'b1;
            loaded_list.push_back(t.entry_index);
          end
        end
      end
      REQ_HEADER: begin
        if (!vtx_open) begin
          acc_sum    = '0;
          held_div   = t.out_count;
          edges_left = t.in_count;
          vtx_open   = 1'b1;
          if (t.in_count == 16'd0) begin
            close_vertex(r);
            return 1'b1;
          end
        end
      end
      REQ_EDGE: begin
        if (vtx_open) begin
          acc_sum    = acc_sum + rank_mem[t.entry_index];
          edges_left = edges_left - 16'd1;
          if (edges_left == 16'd0) begin
            close_vertex(r);
            return 1'b1;
          end
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic rgsd_in_t mk_item(input logic [1:0] kind, input logic [13:0] idx,
                                       input logic [63:0] val, input logic [15:0] ic,
                                       input logic [15:0] oc);
    rgsd_in_t t;
    t.req_type    = kind;
    t.entry_index = idx;
    t.rank_value  = val;
    t.in_count    = ic;
    t.out_count   = oc;
    return t;
  endfunction

  function automatic void add_row(input rgsd_in_t t, input bit typed,
                                  input logic [63:0] w, input logic [13:0] vn);
    dir_row_t row;
    row.item                 = t;
    row.typed                = typed;
    row.want.weight          = w;
    row.want.vertex_number   = vn;
    dir_rows.push_back(row);
  endfunction

  // next random transaction, shaped by the predictor's current state
  function automatic rgsd_in_t pick_item();
    rgsd_in_t t;
    int       roll;
    roll          = $urandom_range(99);
    t.req_type    = REQ_UNUSED;
    t.entry_index = 14'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
    t.rank_value  = {$urandom, $urandom};
    t.in_count    = 16'($urandom);
    t.out_count   = 16'($urandom);
    if (roll < 8) begin
      // broken protocol, ignored by the block
      case ($urandom_range(2))
        0: t.req_type = REQ_UNUSED;
        1: t.req_type = vtx_open ? REQ_HEADER : REQ_EDGE;
        default: begin
          if (vtx_open) begin
            t.req_type    = REQ_LOAD;
            t.entry_index = 14'($urandom);
          end
        end
      endcase
    end else if (vtx_open) begin
      t.req_type = REQ_EDGE;
    end else if (roll < 40) begin
      t.req_type    = REQ_LOAD;
      t.entry_index = $urandom_range(1) ? 14'($urandom_range(63)) : 14'($urandom);
      case ($urandom_range(9))
        0: t.rank_value = '0;
        1: t.rank_value = '1;
        default: ;
      endcase
    end else begin
      t.req_type = REQ_HEADER;
      roll = $urandom_range(99);
      if (roll < 12)      t.in_count = 16'd0;
      else if (roll < 82) t.in_count = 16'($urandom_range(6, 1));
      else                t.in_count = 16'($urandom_range(40, 7));
      roll = $urandom_range(99);
      if (roll < 10)      t.out_count = 16'd0;
      else if (roll < 20) t.out_count = 16'd1;
      else if (roll < 25) t.out_count = 16'hFFFF;
      else if (roll < 65) t.out_count = 16'($urandom_range(10, 2));
    end
    return t;
  endfunction

  // present one transaction, with random idle cycles ahead of it outside the calm stretch
  task automatic send_item(input rgsd_in_t t, input bit typed, input rgsd_out_t want);
    int unsigned mark;
    if (!calm) begin
      while ($urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    row_typed = typed;
    row_want  = want;
    in_item  <= t;
    in_valid <= 1'b1;
    mark = n_taken;
    do @(negedge clk); while (n_taken == mark);
  endtask

  // hold off the sender until every predicted weight has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (weight_q.size() != 0) @(negedge clk);
    n_pauses++;
  endtask

  // receiver stall
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 18);
  end

  // predict on accepted input, check accepted output, watch for a hang
  always @(posedge clk) begin : monitor
    rgsd_out_t got;
    rgsd_out_t want;
    bit        in_fire;
    bit        out_fire;
    if (rst_n) begin
      in_fire  = in_valid && !in_stall;
      out_fire = out_valid && !out_stall;
      if (in_fire) begin
        n_taken++;
        if (gather_step(in_item, got) && !row_typed) weight_q.push_back(got);
        if (row_typed) weight_q.push_back(row_want);
      end
      if (out_fire) begin
        n_weights++;
        if (weight_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected weight, expected none, got %h vertex %0d",
                   $time, out_res.weight, out_res.vertex_number);
        end else begin
          want = weight_q.pop_front();
          if (out_res.weight !== want.weight) begin
            n_errors++;
            $display("%0t: weight mismatch, expected %h, got %h",
                     $time, want.weight, out_res.weight);
          end
          if (out_res.vertex_number !== want.vertex_number) begin
            n_errors++;
            $display("%0t: vertex_number mismatch, expected %0d, got %0d",
                     $time, want.vertex_number, out_res.vertex_number);
          end
        end
      end
      if (in_fire || out_fire) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet);
          $display("rank_gather_sum_divide: mismatch");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    rgsd_out_t none;
    int        n;
    none  = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    add_row(mk_item(REQ_HEADER, 14'd0, 64'd0, 16'd0, 16'd5), 1'b1, 64'd0, 14'd0);
    add_row(mk_item(REQ_LOAD, 14'd0, '1, 16'd0, 16'd0), 1'b0, '0, '0);
    add_row(mk_item(REQ_LOAD, 14'h3FFF, 64'd1, 16'd0, 16'd0), 1'b0, '0, '0);
    add_row(mk_item(REQ_LOAD, 14'd1, 64'd0, 16'd0, 16'd0), 1'b0, '0, '0);
    add_row(mk_item(REQ_LOAD, 14'd2, 64'h8000_0000_0000_0000, 16'd0, 16'd0), 1'b0, '0, '0);
    // edge with no vertex open
    add_row(mk_item(REQ_EDGE, 14'd0, 64'd0, 16'd0, 16'd0), 1'b0, '0, '0);
    // unused request code
    add_row(mk_item(REQ_UNUSED, 14'h3FFF, '1, 16'hFFFF, 16'hFFFF), 1'b0, '0, '0);
    add_row(mk_item(REQ_HEADER, 14'd0, 64'd0, 16'd2, 16'd1), 1'b0, '0, '0);
    // load and header while a vertex is open
    add_row(mk_item(REQ_LOAD, 14'd3, 64'd123, 16'd0, 16'd0), 1'b0, '0, '0);
    add_row(mk_item(REQ_HEADER, 14'h3FFF, '1, 16'hFFFF, 16'hFFFF), 1'b0, '0, '0);
    // all-ones plus one wraps to zero
    add_row(mk_item(REQ_EDGE, 14'd0, 64'd0, 16'd0, 16'd0), 1'b0, '0, '0);
    add_row(mk_item(REQ_EDGE, 14'h3FFF, 64'd0, 16'd0, 16'd0), 1'b1, 64'd0, 14'd1);
    // zero out-count
    add_row(mk_item(REQ_HEADER, 14'd0, 64'd0, 16'd1, 16'd0), 1'b0, '0, '0);
    add_row(mk_item(REQ_EDGE, 14'd0, 64'd0, 16'd0, 16'd0), 1'b1, 64'd0, 14'd2);
    // largest divisor
    add_row(mk_item(REQ_HEADER, 14'd0, 64'd0, 16'd1, 16'hFFFF), 1'b0, '0, '0);
    add_row(mk_item(REQ_EDGE, 14'd0, 64'd0, 16'd0, 16'd0), 1'b1,
            64'h0001_0001_0001_0001, 14'd3);
    add_row(mk_item(REQ_HEADER, 14'd0, 64'd0, 16'd3, 16'd3), 1'b0, '0, '0);
    add_row(mk_item(REQ_EDGE, 14'd2, 64'd0, 16'd0, 16'd0), 1'b0, '0, '0);
    add_row(mk_item(REQ_EDGE, 14'd0, 64'd0, 16'd0, 16'd0), 1'b0, '0, '0);
    add_row(mk_item(REQ_EDGE, 14'd1, 64'd0, 16'd0, 16'd0), 1'b0, '0, '0);
    add_row(mk_item(REQ_LOAD, 14'h3FFF, 64'd0, 16'd0, 16'd0), 1'b0, '0, '0);
    // empty vertex with zero out-count
    add_row(mk_item(REQ_HEADER, 14'd0, 64'd0, 16'd0, 16'd0), 1'b1, 64'd0, 14'd5);
    add_row(mk_item(REQ_HEADER, 14'd0, 64'd0, 16'd1, 16'd2), 1'b0, '0, '0);
    add_row(mk_item(REQ_EDGE, 14'd2, 64'd0, 16'd0, 16'd0), 1'b1,
            64'h4000_0000_0000_0000, 14'd6);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    drain();

    // random sequences, with a stretch of no idling in the middle
    for (n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 500) && (n < 800);
      if (n % 400 == 399) drain();
      send_item(pick_item(), 1'b0, none);
    end
    calm = 1'b0;
    while (vtx_open) send_item(pick_item(), 1'b0, none);
    drain();

    repeat (SETTLE) @(negedge clk);
    if (weight_q.size() != 0) begin
      n_errors++;
      $display("%0t: %0d predicted weights never came out", $time, weight_q.size());
    end
    $display("covered %0d input transactions and %0d weights, %0d drain pauses,",
             n_taken, n_weights, n_pauses);
    $display("including empty, zero-divisor, largest-divisor and wrapping vertices");
    if (n_errors == 0) begin
      $display("rank_gather_sum_divide: match");
    end else begin
      $display("rank_gather_sum_divide: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rgsd_pkg.sv
hdl/rgsd_store.sv
hdl/rgsd_divider.sv
hdl/rank_gather_sum_divide.sv
verif/testbench.sv
